// File: sv/qfir_pkg.sv
// Shared types and constants for the Q31 FIR filter.
// No dependencies; imported by every module of the block.
package qfir_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 32;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int WIDEN_SH   = 16;
    localparam int ACC_W      = PROD_W + WIDEN_SH;
    localparam int COEF_IDX_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_INDEX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_WORD  = 2'd1;

    typedef struct packed {
        logic clear;
        logic issue;
    } mac_ctrl_t;

    typedef struct packed {
        logic busy;
    } mac_stat_t;

endpackage

// File: sv/q31_fir_filter.sv
// Top level of the Q31 FIR filter: handshakes, config registers, tap sequencer.
// Depends on qfir_pkg, qfir_delay_mem, qfir_coef_mem and qfir_mac.
//
//  channel   signals                                    width  word
//  -------   -----------------------------------------  -----  ---------------------------
//  input     in_valid, in_ready, sample_in              16     Q15 audio sample
//  output    out_valid, out_ready, sample_out           16     Q15 filtered sample
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  2/32   0: coef_index, 1: coef_word
//
// For each word, the sample is written at the accepting edge, then the taps
// are read through the single MAC (one tap per cycle off the memory read
// port), the MAC pipeline drains, and the sum is rounded and loaded into the
// output register. A new word is taken only when idle, so a word is not taken
// before the result of the last one has been loaded into the output register.
// Reset clears all control state at once; no clearing pass runs, as a fill
// count and coefficient valid bits make unwritten entries read as zero.
// A stalled output holds its word; the sequencer waits in its last state
// until the output register is free. Config is always ready.
module q31_fir_filter import qfir_pkg::*;
#(
    parameter int TAPS = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [SAMPLE_W-1:0]  sample_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  sample_out,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    localparam int AW     = $clog2(TAPS);
    localparam int CDEPTH = (TAPS < 32) ? TAPS : 32;
    localparam int CAW    = $clog2(CDEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t                     state_reg;
    logic [AW-1:0]              pos_reg;
    logic [AW-1:0]              tap_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;
    logic [COEF_IDX_W-1:0]      coef_index_reg;

    logic                       in_fire;
    logic                       cfg_fire;
    logic                       coef_wr;
    logic                       out_load;
    logic [AW-1:0]              rd_addr;
    mac_ctrl_t                  mac_ctrl;
    mac_stat_t                  mac_stat;
    logic signed [SAMPLE_W-1:0] tap_sample;
    logic signed [COEF_W-1:0]   tap_coef;
    logic signed [SAMPLE_W-1:0] mac_result;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;
    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;

    // Load the output register once the sum is final and the slot is free.
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Drop coefficient writes whose index lies beyond the taps.
    assign coef_wr = cfg_fire && (cfg_index == CFG_COEF_WORD)
                     && (32'(coef_index_reg) < TAPS);

    // Tap k reads the sample k steps behind the write position.
    assign rd_addr = pos_reg - tap_reg;

    assign mac_ctrl.clear = in_fire;
    assign mac_ctrl.issue = (state_reg == S_RUN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_index_reg <= '0;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                CFG_COEF_INDEX: coef_index_reg <= cfg_data[COEF_IDX_W-1:0];
                default:        coef_index_reg <= coef_index_reg;
            endcase
        end
    end

    // Sequencer: state, positions and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            tap_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        tap_reg   <= '0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    // Advance one tap a cycle; leave after the last one.
                    tap_reg <= tap_reg + AW'(1);
                    if (tap_reg == AW'(TAPS - 1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (!mac_stat.busy)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // Hold here while the previous result is still waiting.
                    if (out_load)
                    begin
                        out_data_reg  <= mac_result;
                        pos_reg       <= pos_reg + AW'(1);
                        tap_reg       <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    qfir_delay_mem #(
        .DEPTH (TAPS)
    ) u_delay (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_fire),
        .wr_addr (pos_reg),
        .wr_data (sample_in),
        .rd_en   (mac_ctrl.issue),
        .rd_addr (rd_addr),
        .rd_data (tap_sample)
    );

    qfir_coef_mem #(
        .TAPS (TAPS)
    ) u_coef (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (coef_wr),
        .wr_addr (coef_index_reg[CAW-1:0]),
        .wr_data (cfg_data),
        .rd_en   (mac_ctrl.issue),
        .rd_tap  (tap_reg),
        .rd_data (tap_coef)
    );

    qfir_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (mac_ctrl),
        .tap_sample (tap_sample),
        .tap_coef   (tap_coef),
        .stat       (mac_stat),
        .result     (mac_result)
    );

    // The MAC pipeline is empty whenever a new word may be taken.
    a_idle_mac_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mac_stat.busy)
        else $error("MAC pipeline busy while idle");

    // A result appears only out of the final sequencer state.
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("output loaded outside the done state");

    // Every accepted word starts its tap walk at tap zero.
    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_RUN) && (tap_reg == '0))
        else $error("accepted word did not start the tap walk");

    // The write position moves only when a result is handed over.
    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != $past(pos_reg)) |-> $past(state_reg == S_DONE))
        else $error("write position moved outside the done state");

endmodule

// File: sv/qfir_delay_mem.sv
// Sample ring memory with registered read.
// Depends on qfir_pkg; a fill count stands in for the all-zero reset.
module qfir_delay_mem import qfir_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic signed [SAMPLE_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic signed [SAMPLE_W-1:0] rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] data_reg;
    logic                       hit_reg;
    logic [AW:0]                fill_reg;
    logic [AW:0]                fill_next;
    logic                       rd_hit;

    // Writes start at entry zero and advance by one, so entries below the
    // fill count are exactly the ones written so far.
    assign rd_hit    = fill_reg[AW] || (rd_addr < fill_reg[AW-1:0]);
    assign fill_next = fill_reg + (AW+1)'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en && !fill_reg[AW])
            begin
                fill_reg <= fill_next;
            end
            if (rd_en)
            begin
                hit_reg <= rd_hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

// File: sv/qfir_coef_mem.sv
// Coefficient memory with per-entry valid bits and registered read.
// Depends on qfir_pkg; taps beyond the writable range read as zero.
module qfir_coef_mem import qfir_pkg::*;
#(
    parameter int TAPS = 32
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    wr_en,
    input  logic [$clog2((TAPS < 32) ? TAPS : 32)-1:0] wr_addr,
    input  logic signed [COEF_W-1:0]                wr_data,
    input  logic                                    rd_en,
    input  logic [$clog2(TAPS)-1:0]                 rd_tap,
    output logic signed [COEF_W-1:0]                rd_data
);

    localparam int CDEPTH = (TAPS < 32) ? TAPS : 32;
    localparam int CAW    = $clog2(CDEPTH);

    logic signed [COEF_W-1:0] mem [CDEPTH];
    logic [CDEPTH-1:0]        vld_reg;
    logic signed [COEF_W-1:0] data_reg;
    logic                     hit_reg;
    logic                     in_range;

    assign in_range = (32'(rd_tap) < CDEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= in_range && vld_reg[rd_tap[CAW-1:0]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_tap[CAW-1:0]];
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

// File: sv/qfir_mac.sv
// Shared multiply-accumulate unit with round-to-nearest and Q31 saturation.
// Depends on qfir_pkg (mac_ctrl_t, mac_stat_t, widths).
module qfir_mac import qfir_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_W-1:0] tap_sample,
    input  logic signed [COEF_W-1:0]   tap_coef,
    output mac_stat_t                  stat,
    output logic signed [SAMPLE_W-1:0] result
);

    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(64'h4000_0000);
    localparam logic [31:0]      Q31_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0]      Q31_MIN    = 32'h8000_0000;

    logic                     d1_reg;
    logic                     d2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic [ACC_W-1:0]         rnd;
    logic [32:0]              shifted;
    logic [31:0]              sat;

    assign prod_next = tap_sample * tap_coef;
    // Widening the sample to Q31 is a left shift of the product.
    assign acc_next  = acc_reg + {prod_reg, {WIDEN_SH{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg <= 1'b0;
            d2_reg <= 1'b0;
        end
        else
        begin
            d1_reg <= ctrl.issue;
            d2_reg <= d1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d1_reg)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (d2_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign stat.busy = d1_reg | d2_reg;

    // Round, take bits 63..31 as a 33-bit signed value, clamp to Q31.
    assign rnd     = acc_reg + ROUND_HALF;
    assign shifted = rnd[ACC_W-1:31];

    always_comb
    begin
        unique case (shifted[32:31])
            2'b01:   sat = Q31_MAX;
            2'b10:   sat = Q31_MIN;
            default: sat = shifted[31:0];
        endcase
    end

    assign result = sat[31:16];

endmodule
